// ===== design/tcw_pkg.sv =====
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_MOVE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_CODE   = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'h27;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [1:0]       command;
        logic [7:0]       char_code;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } t_cmd;

    typedef struct packed {
        logic [COL_W-1:0] cursor_column;
        logic [ROW_W-1:0] cursor_row;
        logic [11:0]      cursor_offset;
        logic [7:0]       read_char;
        logic [7:0]       read_attribute;
        logic             scrolled;
    } t_result;

endpackage

// ===== design/tcw_queue.sv =====
module tcw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tcw_pkg::t_cmd  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output tcw_pkg::t_cmd  o_data
);

    localparam int CW = $clog2(tcw_pkg::QDEPTH) + 1;

    tcw_pkg::t_cmd r_mem [tcw_pkg::QDEPTH];
    logic [$clog2(tcw_pkg::QDEPTH)-1:0] r_wp, r_rp;
    logic [CW-1:0]                      r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != CW'(tcw_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{(CW-1){1'b0}}, push} - {{(CW-1){1'b0}}, pop};
        end
    end

endmodule

// ===== design/tcw_exec.sv =====
module tcw_exec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_color,
    input  logic              i_valid,
    output logic              o_ready,
    input  tcw_pkg::t_cmd     i_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output tcw_pkg::t_result  o_res,
    output logic              o_busy
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SRD    = 3'd2;
    localparam logic [2:0] S_SWR    = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    localparam int AW = tcw_pkg::ADDR_W;
    localparam logic [AW-1:0] LAST   = AW'(tcw_pkg::CELLS - 1);
    localparam logic [AW-1:0] BOTTOM = AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
    localparam logic [AW-1:0] STRIDE = AW'(tcw_pkg::COLUMNS);

    logic [15:0] r_mem [tcw_pkg::CELLS];
    logic [15:0] r_rdata;

    logic [2:0]  r_state;
    logic [AW-1:0] r_ptr;
    logic [tcw_pkg::COL_W-1:0] r_col;
    logic [tcw_pkg::ROW_W-1:0] r_row;
    logic        r_scr, r_rd_ok;
    logic [7:0]  r_fill_attr;
    tcw_pkg::t_result r_res;
    logic        r_ovalid;

    logic        we, re;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] wdata;
    logic [AW-1:0] cur_addr, rd_addr;
    logic        cmd_take;
    logic [11:0] offs;

    assign cur_addr = AW'(r_row * STRIDE) + AW'(r_col);
    assign rd_addr  = AW'(i_cmd.row * STRIDE) + AW'(i_cmd.column);
    assign o_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign cmd_take = i_valid && o_ready;
    assign o_valid  = r_ovalid;
    assign o_res    = r_res;
    assign o_busy   = (r_state != S_IDLE);
    assign offs = 12'(r_row * (2 * tcw_pkg::COLUMNS)) + 12'({r_col, 1'b0});

    always_comb begin
        we = 1'b0; re = 1'b0;
        waddr = r_ptr; raddr = r_ptr + STRIDE;
        wdata = {r_fill_attr, tcw_pkg::BLANK_CODE};
        case (r_state)
            S_INIT, S_FILL: we = 1'b1;
            S_SRD:  re = 1'b1;
            S_SWR: begin
                we = 1'b1;
                wdata = (r_ptr >= BOTTOM) ? {r_fill_attr, tcw_pkg::BLANK_CODE} : r_rdata;
            end
            S_IDLE: begin
                if (cmd_take && i_cmd.command == tcw_pkg::CMD_PUT &&
                    i_cmd.char_code != tcw_pkg::NEWLINE_CODE) begin
                    we = 1'b1; waddr = cur_addr; wdata = {i_color, i_cmd.char_code};
                end
                if (cmd_take && i_cmd.command == tcw_pkg::CMD_READ) begin
                    re = 1'b1; raddr = rd_addr;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (re) r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr <= '0;
            r_col <= '0;
            r_row <= '0;
            r_ovalid <= 1'b0;
            r_fill_attr <= tcw_pkg::RESET_COLOR;
            r_scr <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_INIT, S_FILL: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == LAST) r_state <= (r_state == S_INIT) ? S_IDLE : S_OUT;
                end
                S_SRD: r_state <= S_SWR;
                S_SWR: begin
                    r_ptr <= r_ptr + 1'b1;
                    r_state <= (r_ptr == LAST) ? S_OUT : S_SRD;
                end
                S_RDWAIT: r_state <= S_OUT;
                S_OUT: begin
                    r_res.cursor_column  <= r_col;
                    r_res.cursor_row     <= r_row;
                    r_res.cursor_offset  <= offs;
                    r_res.read_char      <= r_rd_ok ? r_rdata[7:0]  : 8'd0;
                    r_res.read_attribute <= r_rd_ok ? r_rdata[15:8] : 8'd0;
                    r_res.scrolled       <= r_scr;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (cmd_take) begin
                        r_scr <= 1'b0;
                        r_rd_ok <= 1'b0;
                        r_fill_attr <= i_color;
                        r_state <= S_OUT;
                        case (i_cmd.command)
                            tcw_pkg::CMD_PUT: begin
                                if (i_cmd.char_code == tcw_pkg::NEWLINE_CODE ||
                                    32'(r_col) + 1 >= tcw_pkg::COLUMNS) begin
                                    r_col <= '0;
                                    if (32'(r_row) + 1 >= tcw_pkg::ROWS) begin
                                        r_scr <= 1'b1;
                                        r_ptr <= '0;
                                        r_state <= S_SRD;
                                    end else begin
                                        r_row <= r_row + 1'b1;
                                    end
                                end else begin
                                    r_col <= r_col + 1'b1;
                                end
                            end
                            tcw_pkg::CMD_MOVE: begin
                                if (32'(i_cmd.column) < tcw_pkg::COLUMNS) r_col <= i_cmd.column;
                                if (32'(i_cmd.row) < tcw_pkg::ROWS) r_row <= i_cmd.row;
                            end
                            tcw_pkg::CMD_CLEAR: begin
                                r_col <= '0;
                                r_row <= '0;
                                r_ptr <= '0;
                                r_state <= S_FILL;
                            end
                            default: begin
                                r_rd_ok <= (32'(i_cmd.column) < tcw_pkg::COLUMNS) &&
                                           (32'(i_cmd.row) < tcw_pkg::ROWS);
                                r_state <= S_RDWAIT;
                            end
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/text_console_writer_top.sv =====
// Channel   | Direction | Payload
// s_axis    | in        | tdata: command, char_code, column, row
// m_axis    | out       | tdata: cursor_column, cursor_row, cursor_offset,
//           |           |        read_char, read_attribute, scrolled
// cfg       | in        | text_color
//
// Put char and move go from idle to the output state in the back end; read passes a
// read-wait state first. Scroll reads then writes every cell; clear only writes each cell.
// After reset the cell memory is filled with blanks; while it fills, the queue takes at
// most two commands and the back end takes none.
// A two-entry queue takes up to two commands while the back end is busy or stalled.
module text_console_writer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // command[1:0], char_code[9:2], column[16:10], row[21:17]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // cursor_column[6:0], cursor_row[11:7],
                                        // cursor_offset[23:12], read_char[31:24],
                                        // read_attribute[39:32], scrolled[40]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    tcw_pkg::t_cmd    in_cmd, q_cmd;
    tcw_pkg::t_result res;
    logic q_valid, q_ready, busy;
    logic [7:0] r_color;

    // Unpack the slave transaction.
    assign in_cmd.command   = s_axis_tdata[1:0];
    assign in_cmd.char_code = s_axis_tdata[9:2];
    assign in_cmd.column    = s_axis_tdata[16:10];
    assign in_cmd.row       = s_axis_tdata[21:17];

    assign o_cfg_ready = 1'b1;

    // Hold the text color; the user must write it only while idle, the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= tcw_pkg::RESET_COLOR;
        end else if (i_cfg_valid) begin
            r_color <= i_cfg_data;
        end
    end

    tcw_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_cmd)
    );

    tcw_exec u_exec (
        .i_clk, .i_rst_n, .i_color(r_color),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res), .o_busy(busy)
    );

    // Pack the result transaction.
    assign m_axis_tdata = {7'd0, res.scrolled, res.read_attribute, res.read_char,
                           res.cursor_offset, res.cursor_row, res.cursor_column};

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[40] |->
            m_axis_tdata[11:7] == 5'(tcw_pkg::ROWS - 1) && m_axis_tdata[6:0] == '0)
        else $error("scroll without cursor at bottom row start");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !(q_valid && q_ready))
        else $error("command taken while back end busy");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[6:0]) < tcw_pkg::COLUMNS)
        else $error("cursor column out of range");

endmodule

// ===== sim/text_console_writer_top_tb.sv =====
module text_console_writer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;

    text_console_writer_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Console shadow: characters, attributes, cursor and color
    logic [7:0]                shadow_char [tcw_pkg::ROWS][tcw_pkg::COLUMNS];
    logic [7:0]                shadow_attr [tcw_pkg::ROWS][tcw_pkg::COLUMNS];
    logic [tcw_pkg::COL_W-1:0] shadow_col;
    logic [tcw_pkg::ROW_W-1:0] shadow_row;
    logic [7:0]                shadow_color;

    tcw_pkg::t_cmd    pending_cmds[$];
    tcw_pkg::t_result expected_results[$];
    int      n_errors = 0;
    int      n_checked = 0;
    int      n_scrolls = 0;
    int      n_cycles = 0;
    bit      idle_enable = 1'b0;
    bit      hold_sender = 1'b0;

    function automatic void blank_screen(input logic [7:0] color);
        for (int r = 0; r < tcw_pkg::ROWS; r++)
            for (int c = 0; c < tcw_pkg::COLUMNS; c++) begin
                shadow_char[r][c] = tcw_pkg::BLANK_CODE;
                shadow_attr[r][c] = color;
            end
    endfunction

    // Advance to the next line; scroll when the bottom row is passed
    function automatic bit line_feed();
        shadow_col = '0;
        if (int'(shadow_row) + 1 >= tcw_pkg::ROWS) begin
            for (int r = 0; r + 1 < tcw_pkg::ROWS; r++)
                for (int c = 0; c < tcw_pkg::COLUMNS; c++) begin
                    shadow_char[r][c] = shadow_char[r+1][c];
                    shadow_attr[r][c] = shadow_attr[r+1][c];
                end
            for (int c = 0; c < tcw_pkg::COLUMNS; c++) begin
                shadow_char[tcw_pkg::ROWS-1][c] = tcw_pkg::BLANK_CODE;
                shadow_attr[tcw_pkg::ROWS-1][c] = shadow_color;
            end
            shadow_row = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
            return 1'b1;
        end
        shadow_row = shadow_row + 1'b1;
        return 1'b0;
    endfunction

    function automatic tcw_pkg::t_result console_step(input tcw_pkg::t_cmd cmd);
        tcw_pkg::t_result res;
        res = '0;
        case (cmd.command)
            tcw_pkg::CMD_PUT: begin
                if (cmd.char_code == tcw_pkg::NEWLINE_CODE) begin
                    res.scrolled = line_feed();
                end else begin
                    shadow_char[shadow_row][shadow_col] = cmd.char_code;
                    shadow_attr[shadow_row][shadow_col] = shadow_color;
                    if (int'(shadow_col) + 1 >= tcw_pkg::COLUMNS) res.scrolled = line_feed();
                    else shadow_col = shadow_col + 1'b1;
                end
            end
            tcw_pkg::CMD_MOVE: begin
                if (cmd.column < tcw_pkg::COLUMNS) shadow_col = cmd.column;
                if (cmd.row < tcw_pkg::ROWS) shadow_row = cmd.row;
            end
            tcw_pkg::CMD_CLEAR: begin
                blank_screen(shadow_color);
                shadow_col = '0;
                shadow_row = '0;
            end
            default: begin
                if (cmd.column < tcw_pkg::COLUMNS && cmd.row < tcw_pkg::ROWS) begin
                    res.read_char = shadow_char[cmd.row][cmd.column];
                    res.read_attribute = shadow_attr[cmd.row][cmd.column];
                end
            end
        endcase
        res.cursor_column = shadow_col;
        res.cursor_row = shadow_row;
        res.cursor_offset = 12'(int'(shadow_row) * 2 * tcw_pkg::COLUMNS +
                                int'(shadow_col) * 2);
        return res;
    endfunction

    function automatic tcw_pkg::t_cmd make_cmd(input logic [1:0] op, input logic [7:0] code,
                                               input logic [tcw_pkg::COL_W-1:0] col,
                                               input logic [tcw_pkg::ROW_W-1:0] row);
        tcw_pkg::t_cmd c;
        c.command = op;
        c.char_code = code;
        c.column = col;
        c.row = row;
        return c;
    endfunction

    // Random command: mostly random character puts with newlines, some moves and reads,
    // rare clears (they walk the whole screen)
    function automatic tcw_pkg::t_cmd random_cmd();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return make_cmd(tcw_pkg::CMD_PUT, 8'($urandom), 7'($urandom), 5'($urandom));
        if (pick < 62)
            return make_cmd(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, 7'($urandom),
                            5'($urandom));
        if (pick < 78)
            return make_cmd(tcw_pkg::CMD_MOVE, 8'($urandom), 7'($urandom), 5'($urandom));
        if (pick < 98)
            return make_cmd(tcw_pkg::CMD_READ, 8'($urandom), 7'($urandom), 5'($urandom));
        return make_cmd(tcw_pkg::CMD_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
    endfunction

    // Driver: present the head of the pending queue; predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(console_step(pending_cmds.pop_front()));
            end
            if ((!s_axis_tvalid || s_axis_tready) && !hold_sender) begin
                if (pending_cmds.size() > 0 &&
                    !(idle_enable && $urandom_range(0, 99) < 23)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {2'b00, pending_cmds[0].row, pending_cmds[0].column,
                                     pending_cmds[0].char_code, pending_cmds[0].command};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end else if (hold_sender && s_axis_tready) begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: drain results, with random back-pressure once idle_enable is set, and compare in order
    always @(posedge i_clk) begin
        tcw_pkg::t_result got, want;
        n_cycles <= n_cycles + 1;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.cursor_column  = m_axis_tdata[6:0];
                got.cursor_row     = m_axis_tdata[11:7];
                got.cursor_offset  = m_axis_tdata[23:12];
                got.read_char      = m_axis_tdata[31:24];
                got.read_attribute = m_axis_tdata[39:32];
                got.scrolled       = m_axis_tdata[40];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (got.scrolled) n_scrolls++;
                    if (got !== want) begin
                        $display("%0t: mismatch expected col=%0d row=%0d off=%0d ch=%h at=%h sc=%b",
                                 $time, want.cursor_column, want.cursor_row,
                                 want.cursor_offset, want.read_char,
                                 want.read_attribute, want.scrolled);
                        $display("%0t:          actual   col=%0d row=%0d off=%0d ch=%h at=%h sc=%b",
                                 $time, got.cursor_column, got.cursor_row,
                                 got.cursor_offset, got.read_char,
                                 got.read_attribute, got.scrolled);
                        n_errors++;
                    end
                end
            end
            m_axis_tready <= !(idle_enable && $urandom_range(0, 99) < 23);
        end
    end

    // Watchdog: even if every command scrolled, the run stays far below this limit
    always @(posedge i_clk) begin
        if (n_cycles > 30_000_000) begin
            $display("text_console_writer_top_tb: errors");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4 * tcw_pkg::CELLS + 20) @(posedge i_clk);
    endtask

    // Write the color register while the console is idle
    task automatic write_color(input logic [7:0] color);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= color;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_color = color;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        repeat (count) pending_cmds.push_back(random_cmd());
    endtask

    initial begin
        blank_screen(tcw_pkg::RESET_COLOR);
        shadow_col = '0;
        shadow_row = '0;
        shadow_color = tcw_pkg::RESET_COLOR;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reads of reset cells, field extremes, wrap, newline, scroll
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 8'hFF, 7'd0, 5'd0));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd79, 5'd24));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd80, 5'd0));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd25));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd127, 5'd31));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_PUT, 8'hFF, 7'd127, 5'd31));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_PUT, 8'h00, 7'd0, 5'd0));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd0));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_MOVE, 8'hFF, 7'd79, 5'd31));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_MOVE, 8'h00, 7'd127, 5'd24));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_PUT, 8'h41, 7'd0, 5'd0));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd79, 5'd24));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd0, 5'd23));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_MOVE, 8'h00, 7'd5, 5'd24));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, 7'd0, 5'd0));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_MOVE, 8'h00, 7'd80, 5'd25));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_PUT, 8'h0A + 8'd1, 7'd0, 5'd0));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_CLEAR, 8'hFF, 7'd127, 5'd31));
        pending_cmds.push_back(make_cmd(tcw_pkg::CMD_READ, 8'h00, 7'd40, 5'd12));

        // Hold the sender until everything predicted so far has come back
        wait_drained();
        write_color(8'h00);
        queue_random(300);
        wait_drained();
        hold_sender = 1'b1;
        while (expected_results.size() != 0) @(posedge i_clk);
        hold_sender = 1'b0;

        write_color(8'hFF);
        idle_enable = 1'b1;
        queue_random(350);
        write_color(8'($urandom));
        queue_random(350);
        write_color(8'h27);
        queue_random(300);
        wait_drained();

        $display("covered %0d commands checked, %0d scrolls, 4 color settings",
                 n_checked, n_scrolls);
        if (n_errors == 0)
            $display("text_console_writer_top_tb: clean");
        else
            $display("text_console_writer_top_tb: errors");
        $finish;
    end
endmodule
